FILE: hdl/sadlm_pkg.sv
// Shared types and constants for the longest prefix match access list.
// No dependencies.
package sadlm_pkg;
	localparam logic [2:0] OP_ADD_ALLOW = 3'd0;
	localparam logic [2:0] OP_DEL_ALLOW = 3'd1;
	localparam logic [2:0] OP_ADD_DENY  = 3'd2;
	localparam logic [2:0] OP_DEL_DENY  = 3'd3;
	localparam logic [2:0] OP_QUERY     = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic        is_ipv6;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [7:0]  prefix_length;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       access_allowed;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		logic        is_query;
		logic        is_add;
		logic        is_deny;
		logic        too_long;
		logic        is_ipv6;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  prefix;
	} cmd_t;

	function automatic logic [127:0] prefix_mask(logic v6, logic [7:0] p);
		logic [127:0] m;
		m = '0;
		for (int i = 0; i < 128; i++) begin
			if (v6) m[127-i] = (8'(i) < p);
			else if (i < 32) m[31-i] = (8'(i) < p);
		end
		return m;
	endfunction
endpackage

FILE: hdl/sadlm_if.sv
// Valid/ready channel interface.
// Depends on nothing; payload type given as a parameter.
interface sadlm_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/subnet_allow_deny_longest_match.sv
// Longest prefix match allow/deny access list. Each request (add, delete or query) is accepted
// by a front stage that checks the prefix length and masks the address, then queued in a
// one-entry command register. The back end walks the whole entry memory, one entry a cycle
// through its single read port, and takes the next request only after the response of the
// current one has been loaded into the response register. A waiting response does not stop
// the next scan; only the final table update of the next request waits for the response
// register to drain. The front can hold one more request meanwhile. Exactly one response
// per request.
// Depends on sadlm_pkg, sadlm_if, sadlm_front and sadlm_back.
module subnet_allow_deny_longest_match import sadlm_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	sadlm_if.sink   req,
	sadlm_if.source rsp
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	// front: classify and mask
	sadlm_front u_front (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready), .in_req(req.data),
		.cmd_valid, .cmd_ready, .cmd
	);

	// back: table scan and update
	sadlm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n,
		.cmd_valid, .cmd_ready, .cmd,
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.data)
	);

`ifndef NO_ASSERTIONS
	// an offered response stays put until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("response handshake");
	// responses with a failed status carry no access bit
	a_deny_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status != ST_OK |-> !rsp.data.access_allowed)
		else $error("access bit on failed command");
`endif
endmodule

FILE: hdl/sadlm_front.sv
// Front end: accepts requests, checks prefix, masks address into a command.
// Uses sadlm_pkg.
module sadlm_front import sadlm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  req_t  in_req,
	output logic  cmd_valid,
	input  logic  cmd_ready,
	output cmd_t  cmd
);
	cmd_t cmd_q;
	logic vld_q;
	cmd_t c;
	logic [127:0] a, m;

	always_comb begin
		c = '0;
		c.is_ipv6 = in_req.is_ipv6;
		c.is_query = (in_req.operation == OP_QUERY);
		c.is_add = (in_req.operation == OP_ADD_ALLOW) || (in_req.operation == OP_ADD_DENY);
		c.is_deny = (in_req.operation == OP_ADD_DENY) || (in_req.operation == OP_DEL_DENY);
		c.too_long = (in_req.operation <= OP_DEL_DENY) &&
			(in_req.prefix_length > (in_req.is_ipv6 ? 8'd128 : 8'd32));
		c.prefix = in_req.prefix_length;
		a = in_req.is_ipv6 ? {in_req.address_high, in_req.address_low}
			: {96'd0, in_req.address_low[31:0]};
		// queries keep the full address; entries get masked here
		m = (c.is_query || in_req.operation > OP_QUERY) ? '1
			: prefix_mask(in_req.is_ipv6, in_req.prefix_length);
		{c.hi, c.lo} = a & m;
		if (in_req.operation > OP_QUERY) begin
			c.is_query = 1'b0; c.is_add = 1'b0; c.prefix = 8'd255; c.too_long = 1'b0;
		end
	end

	assign in_ready = !vld_q || cmd_ready;
	assign cmd_valid = vld_q;
	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (in_ready) vld_q <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) cmd_q <= c;
	end
endmodule

FILE: hdl/sadlm_back.sv
// Back end: scans the table one entry a cycle and executes the command.
// Uses sadlm_pkg.
module sadlm_back import sadlm_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_DONE = 2'd2;

	logic [1:0] state_q;
	cmd_t c_q;
	logic [IW:0] idx_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IW-1:0] ri;
	logic e_deny, e_v6;
	logic [127:0] e_addr;
	logic [7:0] e_pfx;
	logic [1+1+128+8-1:0] mem [TABLE_DEPTH];
	logic [1+1+128+8-1:0] rd_q;
	logic rd_ok_q;
	logic hit_found_q, free_found_q, af_q, df_q;
	logic [IW-1:0] hit_q, free_q;
	logic [7:0] al_q, dl_q;
	logic rsp_v_q;
	rsp_t rsp_q;
	rsp_t rsp_d;
	logic [IW-1:0] rd_idx_q;
	logic match_ex, match_q;
	logic last_rd;
	logic done_go;

	assign ri = idx_q[IW-1:0];
	assign {e_deny, e_v6, e_addr, e_pfx} = rd_q;
	// a waiting response only holds the final write-back, not the next scan
	assign cmd_ready = (state_q == S_IDLE);
	assign done_go = (state_q == S_DONE) && (!rsp_v_q || rsp_ready);
	assign rsp_valid = rsp_v_q;
	assign rsp = rsp_q;

	assign match_ex = (e_deny == c_q.is_deny) && (e_v6 == c_q.is_ipv6) &&
		(e_pfx == c_q.prefix) && (e_addr == {c_q.hi, c_q.lo});
	assign match_q = (e_v6 == c_q.is_ipv6) &&
		((({c_q.hi, c_q.lo}) & prefix_mask(e_v6, e_pfx)) == e_addr);
	assign last_rd = rd_ok_q && (rd_idx_q == IW'(TABLE_DEPTH - 1));

	always_comb begin
		rsp_d = '0;
		if (c_q.is_query) begin
			rsp_d.access_allowed = !df_q || (af_q && (al_q > dl_q));
		end else if (c_q.too_long) begin
			rsp_d.status = ST_TOO_LONG;
		end else if (c_q.prefix == 8'd255) begin
			rsp_d.status = ST_OK;
		end else if (c_q.is_add) begin
			if (!hit_found_q && !free_found_q) rsp_d.status = ST_FULL;
		end else if (!hit_found_q) begin
			rsp_d.status = ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[ri];
		if (done_go && c_q.is_add && !c_q.too_long && !hit_found_q && free_found_q)
			mem[free_q] <= {c_q.is_deny, c_q.is_ipv6, c_q.hi, c_q.lo, c_q.prefix};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			rsp_v_q <= 1'b0;
			rsp_q <= '0;
			rd_ok_q <= 1'b0;
			c_q <= '0;
			idx_q <= '0;
			rd_idx_q <= '0;
			hit_found_q <= 1'b0; free_found_q <= 1'b0;
			hit_q <= '0; free_q <= '0;
			af_q <= 1'b0; df_q <= 1'b0; al_q <= '0; dl_q <= '0;
		end else begin
			if (done_go) rsp_v_q <= 1'b1;
			else if (rsp_ready) rsp_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						c_q <= cmd;
						idx_q <= '0;
						rd_ok_q <= 1'b0;
						hit_found_q <= 1'b0; free_found_q <= 1'b0;
						af_q <= 1'b0; df_q <= 1'b0; al_q <= '0; dl_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue read at idx, evaluate previous one
					if (idx_q < (IW+1)'(TABLE_DEPTH)) idx_q <= idx_q + 1'b1;
					rd_ok_q <= (idx_q < (IW+1)'(TABLE_DEPTH));
					rd_idx_q <= ri;
					if (rd_ok_q) begin
						if (!valid_q[rd_idx_q]) begin
							if (!free_found_q) begin
								free_found_q <= 1'b1; free_q <= rd_idx_q;
							end
						end else if (c_q.is_query) begin
							if (match_q) begin
								if (e_deny) begin
									df_q <= 1'b1;
									if (e_pfx > dl_q) dl_q <= e_pfx;
								end else begin
									af_q <= 1'b1;
									if (e_pfx > al_q) al_q <= e_pfx;
								end
							end
						end else if (match_ex && !hit_found_q) begin
							hit_found_q <= 1'b1; hit_q <= rd_idx_q;
						end
					end
					if (last_rd) state_q <= S_DONE;
				end
				S_DONE: begin
					// wait here while the previous response is still unclaimed
					if (done_go) begin
						rsp_q <= rsp_d;
						state_q <= S_IDLE;
						if (!c_q.is_query && !c_q.too_long && c_q.prefix != 8'd255) begin
							if (c_q.is_add) begin
								if (!hit_found_q && free_found_q) valid_q[free_q] <= 1'b1;
							end else if (hit_found_q) begin
								valid_q[hit_q] <= 1'b0;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
